// ===== hdl/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and constants for the device presence table.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int LIST_LIMIT = 16;
    localparam logic [31:0] OFFLINE_RST = 32'd30000;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_SEEN  = 3'd1;
    localparam logic [2:0] REQ_CHECK = 3'd2;
    localparam logic [2:0] REQ_FIND  = 3'd3;
    localparam logic [2:0] REQ_LIST  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // one memory word: id, address, last-seen time
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] ip;
        logic [31:0] seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/dpt_ram.sv =====
// ----------------------------------------------------------------------------
// dpt_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module dpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/device_presence_table_with_aging_unit.sv =====
// ----------------------------------------------------------------------------
// device_presence_table_with_aging_unit
// Device table keyed by id, with aging and a sorted listing.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_      | in        | req_type, device_id, ip_addr, now_ms, max_count
//  m_      | out       | status, slot, entry_id, entry_ip, entry_online,
//          |           | last_seen_ms, last
//  cfg_    | in        | offline_time_ms
//
// A request walks the table memory one slot a cycle (registered read):
// the scan, a write step and a result step serve add, note seen, check and find.
// A list walk collects up to 16 slots, then a gnome-style insertion sort over
// stored keys runs, then each listed word takes a memory read, then the send.
// Reset clears the used and online flags (flip-flops); no clearing pass.
// A result word waits in the output register while the receiver stalls.
module device_presence_table_with_aging_unit
    import dpt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_device_id,
    input  logic [31:0] s_ip_addr,
    input  logic [31:0] s_now_ms,
    input  logic [4:0]  s_max_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot,
    output logic [31:0] m_entry_id,
    output logic [31:0] m_entry_ip,
    output logic        m_entry_online,
    output logic [31:0] m_last_seen_ms,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LN = (TABLE_DEPTH < LIST_LIMIT) ? TABLE_DEPTH : LIST_LIMIT;
    localparam int LW = $clog2(LN + 1);
    localparam int IW = $clog2(LN);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_WRT  = 8'b00000100,
        S_RESP = 8'b00001000,
        S_SORT = 8'b00010000,
        S_LRD  = 8'b00100000,
        S_LOUT = 8'b01000000,
        S_WAIT = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [31:0] tmo_reg;
    logic [TABLE_DEPTH-1:0] used_reg, online_reg;
    logic [2:0]  req_reg;
    logic [31:0] id_reg, ip_reg, now_reg;
    logic [LW-1:0] maxc_reg;
    logic [AW:0] ptr_reg;          // read address issued
    logic        rv_reg;           // read data valid
    logic [AW-1:0] radr_reg;       // address of read data
    logic        hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic        free_reg;
    logic [AW-1:0] free_slot_reg;
    entry_t      ent_reg;
    // list keys
    logic [AW-1:0] lidx_reg [LN];
    logic [31:0]   lkey_reg [LN];
    logic [LW-1:0] n_reg, i_reg, j_reg, k_reg;
    // output register
    logic        ov_reg;
    logic [1:0]  ost_reg;
    logic [AW-1:0] oslot_reg;
    entry_t      oent_reg;
    logic        oon_reg, olast_reg;

    // memory port
    logic          mwe;
    logic [AW-1:0] mwaddr, mraddr;
    entry_t        mwdata, mrdata;

    // list positions, used only while below the list length
    wire [IW-1:0] i_ix = i_reg[IW-1:0];
    wire [IW-1:0] j_ix = j_reg[IW-1:0];
    wire [IW-1:0] k_ix = k_reg[IW-1:0];
    wire [IW-1:0] n_ix = n_reg[IW-1:0];

    dpt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
        .raddr(mraddr), .rdata(mrdata)
    );

    assign s_ready   = (state_reg == S_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    wire ofree = !ov_reg || m_ready;
    wire o_load = ofree && (state_reg == S_RESP || state_reg == S_WAIT ||
                            state_reg == S_LOUT);

    assign m_valid        = ov_reg;
    assign m_status       = ost_reg;
    assign m_slot         = 4'(oslot_reg);
    assign m_entry_id     = oent_reg.id;
    assign m_entry_ip     = oent_reg.ip;
    assign m_entry_online = oon_reg;
    assign m_last_seen_ms = oent_reg.seen;
    assign m_last         = olast_reg;

    // sort step: key at i versus key at j
    logic [AW-1:0] ki_idx, kj_idx;
    logic          bef;
    always_comb begin
        ki_idx = lidx_reg[i_ix];
        kj_idx = lidx_reg[j_ix];
        if (online_reg[ki_idx] != online_reg[kj_idx]) begin
            bef = online_reg[ki_idx];
        end else begin
            bef = lkey_reg[i_ix] > lkey_reg[j_ix];
        end
    end

    wire scan_done = (ptr_reg == (AW+1)'(TABLE_DEPTH));
    wire [31:0] age = now_reg - mrdata.seen;
    wire is_found = rv_reg && used_reg[radr_reg] && (mrdata.id == id_reg);

    // memory addressing
    always_comb begin
        mraddr = ptr_reg[AW-1:0];
        if (state_reg == S_LRD || state_reg == S_LOUT) begin
            mraddr = lidx_reg[k_ix];
        end
        mwe    = 1'b0;
        mwaddr = hit_reg ? hit_slot_reg : free_slot_reg;
        mwdata = '{id: id_reg, ip: '0, seen: '0};
        if (req_reg == REQ_SEEN) begin
            mwdata = '{id: id_reg, ip: ip_reg, seen: now_reg};
        end
        if (state_reg == S_WRT && (hit_reg || free_reg) &&
            (req_reg == REQ_SEEN || !hit_reg)) begin
            mwe = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tmo_reg    <= OFFLINE_RST;
            used_reg   <= '0;
            online_reg <= '0;
            ov_reg     <= 1'b0;
            rv_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tmo_reg <= cfg_data;
            end
            // hold the result word until taken
            if (o_load) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
            rv_reg   <= (state_reg == S_SCAN) && !scan_done;
            radr_reg <= ptr_reg[AW-1:0];
            case (state_reg)
                // take a request word
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg  <= s_req_type;
                        id_reg   <= s_device_id;
                        ip_reg   <= s_ip_addr;
                        now_reg  <= s_now_ms;
                        maxc_reg <= (s_max_count > 5'(LN)) ? LW'(LN)
                                                           : LW'(s_max_count);
                        ptr_reg  <= '0;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        n_reg    <= '0;
                        if (s_req_type <= REQ_LIST) begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                // walk all slots, one read a cycle
                S_SCAN: begin
                    if (!scan_done) begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    if (is_found && !hit_reg) begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= radr_reg;
                        ent_reg      <= mrdata;
                    end
                    if (rv_reg && !used_reg[radr_reg] && !free_reg) begin
                        free_reg      <= 1'b1;
                        free_slot_reg <= radr_reg;
                    end
                    if (rv_reg && req_reg == REQ_CHECK && used_reg[radr_reg] &&
                        online_reg[radr_reg] && age > tmo_reg) begin
                        online_reg[radr_reg] <= 1'b0;
                    end
                    if (rv_reg && req_reg == REQ_LIST && used_reg[radr_reg] &&
                        n_reg < maxc_reg) begin
                        lidx_reg[n_ix] <= radr_reg;
                        lkey_reg[n_ix] <= mrdata.seen;
                        n_reg <= n_reg + 1'b1;
                    end
                    if (scan_done && !rv_reg) begin
                        if (req_reg == REQ_LIST) begin
                            i_reg     <= LW'(1);
                            j_reg     <= '0;
                            state_reg <= S_SORT;
                        end else begin
                            state_reg <= S_WRT;
                        end
                    end
                end
                // update entry and flags
                S_WRT: begin
                    if (req_reg == REQ_ADD || req_reg == REQ_SEEN) begin
                        if (!hit_reg && free_reg) begin
                            used_reg[free_slot_reg]   <= 1'b1;
                            online_reg[free_slot_reg] <= (req_reg == REQ_SEEN);
                            hit_slot_reg <= free_slot_reg;
                            ent_reg      <= mwdata;
                            hit_reg      <= 1'b1;
                        end else if (hit_reg && req_reg == REQ_SEEN) begin
                            online_reg[hit_slot_reg] <= 1'b1;
                            ent_reg <= mwdata;
                        end
                    end
                    state_reg <= S_RESP;
                end
                // send the single result word
                S_RESP: begin
                    if (ofree) begin
                        olast_reg <= 1'b1;
                        if (hit_reg && req_reg != REQ_CHECK) begin
                            ost_reg   <= ST_OK;
                            oslot_reg <= hit_slot_reg;
                            oent_reg  <= ent_reg;
                            oon_reg   <= online_reg[hit_slot_reg];
                        end else begin
                            oslot_reg <= '0;
                            oent_reg  <= '0;
                            oon_reg   <= 1'b0;
                            if (req_reg == REQ_FIND) begin
                                ost_reg <= ST_NOTFOUND;
                            end else if (req_reg == REQ_CHECK) begin
                                ost_reg <= ST_OK;
                            end else begin
                                ost_reg <= ST_FULL;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                // insertion sort: swap i down while it goes before j
                S_SORT: begin
                    if (i_reg >= n_reg) begin
                        k_reg     <= '0;
                        state_reg <= (n_reg == '0) ? S_WAIT : S_LRD;
                    end else if (bef) begin
                        lidx_reg[i_ix] <= lidx_reg[j_ix];
                        lidx_reg[j_ix] <= lidx_reg[i_ix];
                        lkey_reg[i_ix] <= lkey_reg[j_ix];
                        lkey_reg[j_ix] <= lkey_reg[i_ix];
                        if (j_reg == '0) begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg;
                        end else begin
                            i_reg <= j_reg;
                            j_reg <= j_reg - 1'b1;
                        end
                    end else begin
                        // advance to the next pair
                        i_reg <= i_reg + 1'b1;
                        j_reg <= i_reg;
                    end
                end
                // list empty result
                S_WAIT: begin
                    if (ofree) begin
                        olast_reg <= 1'b1;
                        ost_reg   <= ST_EMPTY;
                        oslot_reg <= '0;
                        oent_reg  <= '0;
                        oon_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                // read a listed entry
                S_LRD: begin
                    state_reg <= S_LOUT;
                end
                // send a listed entry
                S_LOUT: begin
                    if (ofree) begin
                        ost_reg   <= ST_OK;
                        oslot_reg <= lidx_reg[k_ix];
                        oent_reg  <= mrdata;
                        oon_reg   <= online_reg[lidx_reg[k_ix]];
                        olast_reg <= (k_reg + 1'b1 == n_reg);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg + 1'b1 == n_reg) ? S_IDLE : S_LRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the device presence table, predicts every result
// word from a behavioral table model and checks the words field by field.
// ----------------------------------------------------------------------------
module testbench
    import dpt_pkg::*;
();

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] id;
        logic [31:0] ip;
        logic        online;
        logic [31:0] seen;
        logic        last;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic [31:0] s_device_id = '0;
    logic [31:0] s_ip_addr = '0;
    logic [31:0] s_now_ms = '0;
    logic [4:0]  s_max_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_slot;
    logic [31:0] m_entry_id;
    logic [31:0] m_entry_ip;
    logic        m_entry_online;
    logic [31:0] m_last_seen_ms;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // table model
    logic [31:0] aging_limit;
    bit          used_q [SLOTS];
    bit          online_q [SLOTS];
    logic [31:0] id_q [SLOTS];
    logic [31:0] ip_q [SLOTS];
    logic [31:0] seen_q [SLOTS];

    word_t expected_words [$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    hold_off = 1'b0;
    bit    busy_rx = 1'b1;

    always #1 aclk = ~aclk;

    device_presence_table_with_aging_unit DUT (.*);

    // count cycles and stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random receiver stalls, with a long hold-off on demand
    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else if (!busy_rx)
            m_ready <= 1'b1;
        else if ($urandom_range(9) < 3)
            m_ready <= 1'b0;
        else
            m_ready <= 1'b1;
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        word_t got, exp_w;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_slot, m_entry_id, m_entry_ip, m_entry_online,
                   m_last_seen_ms, m_last};
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
            end else begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d sl=%0d id=%h ip=%h on=%0d",
                                  " t=%h l=%0d / got st=%0d sl=%0d id=%h ip=%h",
                                  " on=%0d t=%h l=%0d"},
                            exp_w.status, exp_w.slot, exp_w.id, exp_w.ip,
                            exp_w.online, exp_w.seen, exp_w.last, got.status,
                            got.slot, got.id, got.ip, got.online, got.seen,
                            got.last);
                end
            end
        end
    end

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (used_q[i] && id_q[i] == key) return i;
        return -1;
    endfunction

    function automatic int claim_slot(logic [31:0] key);
        int s;
        s = find_slot(key);
        if (s >= 0) return s;
        for (int i = 0; i < SLOTS; i++)
            if (!used_q[i]) begin
                used_q[i] = 1;
                id_q[i] = key;
                ip_q[i] = '0;
                online_q[i] = 0;
                seen_q[i] = '0;
                return i;
            end
        return -1;
    endfunction

    function automatic word_t make_word(logic [1:0] st, int s, bit fin);
        word_t w;
        w = '0;
        w.status = st;
        if (s >= 0) begin
            w.slot = s[3:0];
            w.id = id_q[s];
            w.ip = ip_q[s];
            w.online = online_q[s];
            w.seen = seen_q[s];
        end
        w.last = fin;
        return w;
    endfunction

    function automatic bit ranks_ahead(int a, int b);
        if (online_q[a] != online_q[b]) return online_q[a];
        return seen_q[a] > seen_q[b];
    endfunction

    // apply one request to the table model and queue its result words
    function automatic void predict_request(logic [2:0] req, logic [31:0] key,
                                            logic [31:0] addr, logic [31:0] now,
                                            logic [4:0] count);
        int s, n, limit, k, j;
        int order [SLOTS];
        case (req)
            REQ_ADD: begin
                s = claim_slot(key);
                expected_words.push_back(make_word(s < 0 ? ST_FULL : ST_OK, s, 1));
            end
            REQ_SEEN: begin
                s = claim_slot(key);
                if (s >= 0) begin
                    ip_q[s] = addr;
                    online_q[s] = 1;
                    seen_q[s] = now;
                end
                expected_words.push_back(make_word(s < 0 ? ST_FULL : ST_OK, s, 1));
            end
            REQ_CHECK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (used_q[i] && online_q[i] && 32'(now - seen_q[i]) > aging_limit)
                        online_q[i] = 0;
                expected_words.push_back(make_word(ST_OK, -1, 1));
            end
            REQ_FIND: begin
                s = find_slot(key);
                expected_words.push_back(make_word(s < 0 ? ST_NOTFOUND : ST_OK, s, 1));
            end
            REQ_LIST: begin
                limit = count > LIST_LIMIT ? LIST_LIMIT : int'(count);
                n = 0;
                for (int i = 0; i < SLOTS && n < limit; i++)
                    if (used_q[i]) order[n++] = i;
                for (int i = 1; i < n; i++) begin
                    k = order[i];
                    j = i - 1;
                    while (j >= 0 && ranks_ahead(k, order[j])) begin
                        order[j + 1] = order[j];
                        j--;
                    end
                    order[j + 1] = k;
                end
                if (n == 0)
                    expected_words.push_back(make_word(ST_EMPTY, -1, 1));
                for (int i = 0; i < n; i++)
                    expected_words.push_back(make_word(ST_OK, order[i], i == n - 1));
            end
            default: ;
        endcase
    endfunction

    // send one request word after a random gap and predict its results
    task automatic send_request(logic [2:0] req, logic [31:0] key,
                                logic [31:0] addr, logic [31:0] now,
                                logic [4:0] count);
        int gap;
        gap = ($urandom_range(9) == 0) ? 1 + $urandom_range(40) : 1 + $urandom_range(2);
        if (!busy_rx) gap = 1;
        repeat (gap) @(posedge aclk);
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_device_id <= key;
        s_ip_addr   <= addr;
        s_now_ms    <= now;
        s_max_count <= count;
        do @(posedge aclk); while (!s_ready);
        predict_request(req, key, addr, now, count);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_aging_limit(logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        aging_limit = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_key();
        // small key pool so entries are revisited often
        return ($urandom_range(3) == 0) ? $urandom() : 32'(32'hA000 + $urandom_range(19));
    endfunction

    // extremes of fields, each request type, empty list, unknown types
    task automatic test_directed();
        send_request(REQ_LIST, '0, '0, '0, 5'd16);
        send_request(REQ_FIND, 32'hFFFF_FFFF, '0, '0, '0);
        send_request(REQ_CHECK, '0, '0, 32'hFFFF_FFFF, '0);
        send_request(REQ_ADD, '0, '0, '0, '0);
        send_request(REQ_ADD, '0, 32'hFFFF_FFFF, '0, '0);
        send_request(REQ_SEEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_request(REQ_SEEN, 32'h1234_5678, 32'hC0A8_0001, 32'd100, '0);
        send_request(3'd5, 32'h1, 32'h1, 32'h1, 5'd31);
        send_request(3'd7, 32'h2, 32'h2, 32'h2, 5'd1);
        send_request(REQ_FIND, 32'h1234_5678, '0, '0, '0);
        send_request(REQ_LIST, '0, '0, '0, 5'd0);
        send_request(REQ_LIST, '0, '0, '0, 5'd31);
        send_request(REQ_CHECK, '0, '0, 32'd100 + 32'd30000, '0);
        send_request(REQ_CHECK, '0, '0, 32'd100 + 32'd30001, '0);
        send_request(REQ_LIST, '0, '0, '0, 5'd2);
        // fill the table then overflow it
        for (int i = 0; i < 16; i++)
            send_request(REQ_SEEN, 32'hB000 + i, $urandom(), $urandom(), '0);
        send_request(REQ_ADD, 32'hDEAD_BEEF, '0, '0, '0);
        send_request(REQ_SEEN, 32'hDEAD_BEEF, 32'h1, 32'h1, '0);
        send_request(REQ_LIST, '0, '0, '0, 5'd16);
    endtask

    // random requests over a small key pool, now and then an unknown type
    task automatic test_random(int count_items);
        logic [2:0] req;
        for (int i = 0; i < count_items; i++) begin
            req = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            send_request(req, rand_key(), $urandom(),
                         ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(60000)),
                         5'($urandom_range(31)));
        end
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_request(REQ_LIST, '0, '0, '0, 5'd16);
        join
        wait_drained();
    endtask

    initial begin
        aging_limit = OFFLINE_RST;
        for (int i = 0; i < SLOTS; i++) begin
            used_q[i] = 0;
            online_q[i] = 0;
            id_q[i] = '0;
            ip_q[i] = '0;
            seen_q[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        write_aging_limit(32'd0);
        test_random(20);
        write_aging_limit(32'hFFFF_FFFF);
        test_random(20);
        write_aging_limit(32'($urandom_range(50000)));
        busy_rx = 1'b0;
        test_random(10);
        busy_rx = 1'b1;
        test_random(15);
        wait_drained();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
